// ===== rtl/qrm_pkg.sv =====
// Package for the quaternion to rotation matrix block.
// Holds widths, register codes and the divider pipeline payload type.
// Used by every module of the block; depends on nothing.
package qrm_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int WORD_W     = 16;
   localparam int SQ_W       = 31;               // square of a 16-bit signed value
   localparam int PROD_W     = 32;               // cross product, signed
   localparam int N2_W       = 33;               // squared length, up to 2^32
   localparam int REM_W      = 34;               // partial remainder after shift
   localparam int NUM_W      = 35;               // signed numerator
   localparam int QB         = FRAC_BITS + 2;    // quotient bits, one per cell
   localparam int NUM_CELLS  = QB;
   localparam int NLANE      = 9;
   localparam int Q_W        = QB - 1;           // rounded magnitude
   localparam int SAT_W      = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;

   localparam logic [Q_W-1:0]    ONE_Q   = Q_W'(1) << FRAC_BITS;
   localparam logic [WORD_W-1:0] ONE_SAT =
      (FRAC_BITS >= 15) ? WORD_W'(32767) : WORD_W'(1) << FRAC_BITS;

   localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
   localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_W'(32768);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_NORM_SQ = CSR_IDX_W'(0);
   localparam logic [WORD_W-1:0]    MIN_NORM_SQ_RST = WORD_W'(1);

   // lane order: e0 e1 e2 e4 e5 e6 e8 e9 e10
   typedef struct packed {
      logic [N2_W-1:0]                den;
      logic [NLANE-1:0]               neg;
      logic [NLANE-1:0][REM_W-1:0]    rem;
      logic [NLANE-1:0][QB-1:0]       quo;
      logic                           degen;
   } div_type;

endpackage

// ===== rtl/qrm_if.sv =====
// Channel interfaces for the quaternion to rotation matrix block.
// qrm_req_if carries one quaternion, qrm_rsp_if one matrix result.
// Depends on nothing.
interface qrm_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] qx;
   logic signed [15:0] qy;
   logic signed [15:0] qz;
   logic signed [15:0] qw;
   modport source (output valid, qx, qy, qz, qw, input ready);
   modport sink   (input valid, qx, qy, qz, qw, output ready);
endinterface

interface qrm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] e0;
   logic signed [15:0] e1;
   logic signed [15:0] e2;
   logic signed [15:0] e4;
   logic signed [15:0] e5;
   logic signed [15:0] e6;
   logic signed [15:0] e8;
   logic signed [15:0] e9;
   logic signed [15:0] e10;
   logic               degenerate;
   modport source (output valid, e0, e1, e2, e4, e5, e6, e8, e9, e10, degenerate,
                   input ready);
   modport sink   (input valid, e0, e1, e2, e4, e5, e6, e8, e9, e10, degenerate,
                   output ready);
endinterface

// ===== rtl/qrm_prod.sv =====
// Front end: products of the quaternion components, then squared length,
// numerators, signs and the degenerate test. Two register stages.
// Depends on qrm_pkg.
module qrm_prod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [15:0]            qx,
   input  logic signed [15:0]            qy,
   input  logic signed [15:0]            qz,
   input  logic signed [15:0]            qw,
   input  logic [qrm_pkg::WORD_W-1:0]    min_norm_sq,
   output logic                          out_valid,
   output qrm_pkg::div_type              out_d
);
   import qrm_pkg::*;

   logic                     p_valid_ff;
   logic [SQ_W-1:0]          xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic                     s_valid_ff;
   div_type                  s_d_ff, s_d_in;

   logic signed [PROD_W-1:0] pxx, pyy, pzz, pww;

   function automatic logic signed [NUM_W-1:0] diag(input logic [N2_W-1:0] n,
                                                     input logic [SQ_W-1:0] a,
                                                     input logic [SQ_W-1:0] b);
      logic signed [NUM_W-1:0] s;
      s = $signed({4'b0, a}) + $signed({4'b0, b});
      return $signed({2'b0, n}) - (s <<< 1);
   endfunction

   function automatic logic signed [NUM_W-1:0] offd(input logic signed [PROD_W-1:0] a,
                                                     input logic signed [PROD_W-1:0] b,
                                                     input logic sub);
      logic signed [NUM_W-1:0] ea, eb, s;
      ea = {{(NUM_W-PROD_W){a[PROD_W-1]}}, a};
      eb = {{(NUM_W-PROD_W){b[PROD_W-1]}}, b};
      s  = sub ? ea - eb : ea + eb;
      return s <<< 1;
   endfunction

   assign pxx = qx * qx;
   assign pyy = qy * qy;
   assign pzz = qz * qz;
   assign pww = qw * qw;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in_valid;
         s_valid_ff <= p_valid_ff;
      end
      if (adv) begin
         xx_ff  <= pxx[SQ_W-1:0];
         yy_ff  <= pyy[SQ_W-1:0];
         zz_ff  <= pzz[SQ_W-1:0];
         ww_ff  <= pww[SQ_W-1:0];
         xy_ff  <= qx * qy;
         xz_ff  <= qx * qz;
         yz_ff  <= qy * qz;
         wx_ff  <= qw * qx;
         wy_ff  <= qw * qy;
         wz_ff  <= qw * qz;
         s_d_ff <= s_d_in;
      end
   end

   always_comb begin
      logic [N2_W-1:0]                 n2;
      logic signed [NLANE-1:0][NUM_W-1:0] num;
      logic [NUM_W-1:0]                mag;
      n2 = N2_W'(xx_ff) + N2_W'(yy_ff) + N2_W'(zz_ff) + N2_W'(ww_ff);
      num[0] = diag(n2, yy_ff, zz_ff);
      num[1] = offd(xy_ff, wz_ff, 1'b0);
      num[2] = offd(xz_ff, wy_ff, 1'b1);
      num[3] = offd(xy_ff, wz_ff, 1'b1);
      num[4] = diag(n2, xx_ff, zz_ff);
      num[5] = offd(yz_ff, wx_ff, 1'b0);
      num[6] = offd(xz_ff, wy_ff, 1'b0);
      num[7] = offd(yz_ff, wx_ff, 1'b1);
      num[8] = diag(n2, xx_ff, yy_ff);
      s_d_in       = '0;
      s_d_in.den   = n2;
      s_d_in.degen = (n2 == '0) || (n2 < N2_W'(min_norm_sq));
      for (int i = 0; i < NLANE; i++) begin
         s_d_in.neg[i] = num[i][NUM_W-1];
         mag = num[i][NUM_W-1] ? -num[i] : num[i];
         s_d_in.rem[i] = mag[REM_W-1:0];
      end
   end

   assign out_valid = s_valid_ff;
   assign out_d     = s_d_ff;

endmodule

// ===== rtl/qrm_div_cell.sv =====
// One cell of the divider chain: settles one quotient bit in each of the
// nine lanes and hands remainder and quotient to the next cell.
// Depends on qrm_pkg.
module qrm_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  qrm_pkg::div_type in_d,
   output logic             out_valid,
   output qrm_pkg::div_type out_d
);
   import qrm_pkg::*;

   logic    valid_ff;
   div_type d_ff, d_in;

   always_comb begin
      logic             ge;
      logic [REM_W-1:0] r;
      d_in = in_d;
      for (int i = 0; i < NLANE; i++) begin
         ge = in_d.rem[i] >= REM_W'(in_d.den);
         r  = ge ? in_d.rem[i] - REM_W'(in_d.den) : in_d.rem[i];
         // remainder is now below den, so the shift cannot overflow
         d_in.rem[i] = r << 1;
         d_in.quo[i] = {in_d.quo[i][QB-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_d     = d_ff;

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Quaternion to 3x3 rotation matrix, Q1.14 in and out. One quaternion is
// taken per clock cycle while the pipeline advances, and its matrix passes
// two front-end stages for products and sums, then a chain of FRAC_BITS + 2
// divider cells that each settle one quotient bit of all nine words, then a
// rounding and output register. The whole pipeline holds while a finished
// result waits. min_norm_sq sits at byte 0.
// Depends on qrm_pkg, qrm_if, qrm_prod and qrm_div_cell.
module quaternion_to_rotation_matrix (
   input  logic                              clock,
   input  logic                              reset,
   qrm_req_if.sink                           req,
   qrm_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qrm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [qrm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [qrm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import qrm_pkg::*;

   logic                   adv;
   logic [WORD_W-1:0]      min_norm_sq_ff;
   logic [NUM_CELLS:0]     chain_v;
   div_type                chain_d [NUM_CELLS+1];
   logic                   out_valid_ff;
   logic [NLANE-1:0][WORD_W-1:0] word_ff, word_in;
   logic                   degen_ff;

   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_MIN_NORM_SQ) ?
                       CSR_DATA_W'(min_norm_sq_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_sq_ff <= MIN_NORM_SQ_RST;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[CSR_ADDR_W-1:2] == REG_MIN_NORM_SQ) begin
         min_norm_sq_ff <= csr_pwdata[WORD_W-1:0];
      end
   end

   qrm_prod u_prod (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req.valid),
      .qx          (req.qx),
      .qy          (req.qy),
      .qz          (req.qz),
      .qw          (req.qw),
      .min_norm_sq (min_norm_sq_ff),
      .out_valid   (chain_v[0]),
      .out_d       (chain_d[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      qrm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_v[k]),
         .in_d      (chain_d[k]),
         .out_valid (chain_v[k+1]),
         .out_d     (chain_d[k+1])
      );
   end

   // round half away from zero, clamp to one, then to the word range; a degenerate input gives the identity
   always_comb begin
      logic [QB-1:0]           t1;
      logic [Q_W-1:0]          q;
      logic signed [SAT_W-1:0] sv;
      for (int i = 0; i < NLANE; i++) begin
         t1 = chain_d[NUM_CELLS].quo[i] + QB'(1);
         q  = t1[QB-1:1];
         if (q > ONE_Q) begin
            q = ONE_Q;
         end
         sv = $signed(SAT_W'(q));
         if (chain_d[NUM_CELLS].neg[i]) begin
            sv = -sv;
         end
         if (sv > SAT_MAX) begin
            sv = SAT_MAX;
         end else if (sv < SAT_MIN) begin
            sv = SAT_MIN;
         end
         word_in[i] = sv[WORD_W-1:0];
         if (chain_d[NUM_CELLS].degen) begin
            word_in[i] = (i == 0 || i == 4 || i == 8) ? ONE_SAT : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= chain_v[NUM_CELLS];
      end
      if (adv) begin
         word_ff  <= word_in;
         degen_ff <= chain_d[NUM_CELLS].degen;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.e0         = word_ff[0];
   assign rsp.e1         = word_ff[1];
   assign rsp.e2         = word_ff[2];
   assign rsp.e4         = word_ff[3];
   assign rsp.e5         = word_ff[4];
   assign rsp.e6         = word_ff[5];
   assign rsp.e8         = word_ff[6];
   assign rsp.e9         = word_ff[7];
   assign rsp.e10        = word_ff[8];
   assign rsp.degenerate = degen_ff;

endmodule

// ===== tb/quaternion_to_rotation_matrix_tb.sv =====
// Testbench for quaternion_to_rotation_matrix: drives quaternions and APB writes,
// predicts each matrix in a scoreboard class and checks every result transfer.
// Depends on qrm_pkg and the channel interfaces in qrm_if.
`timescale 1ns / 1ps

module quaternion_to_rotation_matrix_tb;
   import qrm_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int PIPE_CYCLES = 2 + FRAC_BITS + 2 + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_WAIT    = 12;
   localparam int PHASE_ITEMS = 340;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MIN_NORM_SQ = CSR_ADDR_W'(REG_MIN_NORM_SQ) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED    = CSR_ADDR_W'(4);

   typedef struct {
      logic signed [15:0] x, y, z, w;
   } quat_type;

   typedef struct {
      logic signed [15:0] e[NLANE];
      logic               degen;
   } matrix_type;

   class matrix_scoreboard;
      matrix_type  pending[$];
      logic [15:0] min_norm;
      int          errors;

      function new();
         min_norm = MIN_NORM_SQ_RST;
         errors   = 0;
      endfunction

      // round(num * ONE / den), halves away from zero, clamped to +-ONE
      function logic signed [15:0] round_ratio(longint num, longint den);
         longint mag, q;
         mag = (num < 0) ? -num : num;
         q   = (2 * mag * ONE + den) / (2 * den);
         if (q > ONE) q = ONE;
         return (num < 0) ? 16'(-q) : 16'(q);
      endfunction

      function matrix_type rotation_of(quat_type q);
         matrix_type m;
         longint x, y, z, w, n2;
         x  = q.x;
         y  = q.y;
         z  = q.z;
         w  = q.w;
         n2 = x*x + y*y + z*z + w*w;
         if (n2 == 0 || n2 < min_norm) begin
            foreach (m.e[i]) m.e[i] = '0;
            m.e[0]  = 16'(ONE);
            m.e[4]  = 16'(ONE);
            m.e[8]  = 16'(ONE);
            m.degen = 1'b1;
            return m;
         end
         m.e[0]  = round_ratio(n2 - 2*(y*y + z*z), n2);
         m.e[1]  = round_ratio(2*(x*y + w*z), n2);
         m.e[2]  = round_ratio(2*(x*z - w*y), n2);
         m.e[3]  = round_ratio(2*(x*y - w*z), n2);
         m.e[4]  = round_ratio(n2 - 2*(x*x + z*z), n2);
         m.e[5]  = round_ratio(2*(y*z + w*x), n2);
         m.e[6]  = round_ratio(2*(x*z + w*y), n2);
         m.e[7]  = round_ratio(2*(y*z - w*x), n2);
         m.e[8]  = round_ratio(n2 - 2*(x*x + y*y), n2);
         m.degen = 1'b0;
         return m;
      endfunction

      function void note_quat(quat_type q);
         pending.push_back(rotation_of(q));
      endfunction

      function void check_matrix(matrix_type got);
         matrix_type exp_m;
         bit         bad;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer, degenerate=%0b", got.degen);
            return;
         end
         exp_m = pending.pop_front();
         bad   = (exp_m.degen !== got.degen);
         foreach (got.e[i]) if (exp_m.e[i] !== got.e[i]) bad = 1;
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("matrix mismatch: degenerate exp %0b got %0b", exp_m.degen, got.degen);
               foreach (got.e[i])
                  $display("  lane %0d exp %0d got %0d", i, exp_m.e[i], got.e[i]);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;
   int unsigned cycles;
   bit          calm_tx, calm_rx;

   qrm_req_if req_if ();
   qrm_rsp_if rsp_if ();

   matrix_scoreboard sb = new();

   quaternion_to_rotation_matrix u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_MIN_NORM_SQ) sb.min_norm = data[15:0];
   endtask

   // hold until every expected matrix is back, then let the pipeline settle
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 8) @(posedge clock);
   endtask

   task automatic send_quat(quat_type q);
      int gap;
      gap = draw_wait(calm_tx);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.qx    <= q.x;
      req_if.qy    <= q.y;
      req_if.qz    <= q.z;
      req_if.qw    <= q.w;
      do @(posedge clock); while (!req_if.ready);
      sb.note_quat(q);
   endtask

   task automatic send4(int x, int y, int z, int w);
      quat_type q;
      q.x = 16'(x);
      q.y = 16'(y);
      q.z = 16'(z);
      q.w = 16'(w);
      send_quat(q);
   endtask

   function automatic logic signed [15:0] rand_word(int mode);
      int k;
      case (mode)
         0: return 16'($urandom);
         1: begin
            k = $urandom_range(0, 8);
            return 16'($signed($urandom_range(0, (2 << k) - 1)) - (1 << k));
         end
         2: return 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
         default: return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(0);
      endcase
   endfunction

   task automatic send_random();
      quat_type q;
      int       mode;
      mode = $urandom_range(0, 3);
      q.x  = rand_word(mode);
      q.y  = rand_word(mode);
      q.z  = rand_word(mode);
      q.w  = rand_word(mode);
      send_quat(q);
   endtask

   // result side: random stalls with calm stretches
   initial begin : rsp_side
      int stall;
      int n;
      matrix_type got;
      rsp_if.ready = 1'b0;
      n = 0;
      wait (reset === 1'b0);
      forever begin
         if (n % 80 == 0) calm_rx = ($urandom_range(0, 2) == 0);
         n++;
         stall = draw_wait(calm_rx);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.e[0]  = rsp_if.e0;
         got.e[1]  = rsp_if.e1;
         got.e[2]  = rsp_if.e2;
         got.e[3]  = rsp_if.e4;
         got.e[4]  = rsp_if.e5;
         got.e[5]  = rsp_if.e6;
         got.e[6]  = rsp_if.e8;
         got.e[7]  = rsp_if.e9;
         got.e[8]  = rsp_if.e10;
         got.degen = rsp_if.degenerate;
         sb.check_matrix(got);
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] thresholds[5];
      cycles       = 0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.qx    = '0;
      req_if.qy    = '0;
      req_if.qz    = '0;
      req_if.qw    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      calm_tx      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset threshold
      send4(0, 0, 0, 0);
      send4(0, 0, 0, ONE);
      send4(ONE, 0, 0, 0);
      send4(0, ONE, 0, 0);
      send4(0, 0, ONE, 0);
      send4(0, 0, 0, -ONE);
      send4(-32768, -32768, -32768, -32768);
      send4(32767, 32767, 32767, 32767);
      send4(32767, -32768, 32767, -32768);
      send4(1, 0, 0, 0);
      send4(0, 0, 0, -1);
      send4(-1, -1, -1, -1);
      send4(8192, 8192, 8192, 8192);
      send4(100, 200, -300, 400);
      send4(-32768, 0, 0, 0);
      req_if.valid <= 1'b0;
      drain();

      // threshold at the top: boundary of the degenerate case
      csr_write(ADDR_MIN_NORM_SQ, 32'd65535);
      send4(255, 0, 0, 0);
      send4(256, 0, 0, 0);
      send4(0, 0, 0, -256);
      send4(181, 181, 0, 0);
      send4(128, 128, 128, 128);
      req_if.valid <= 1'b0;
      drain();

      thresholds[0] = 32'd0;
      thresholds[1] = 32'd65535;
      thresholds[2] = $urandom_range(2, 65534);
      thresholds[3] = {$urandom} | 32'h0001_0000;   // upper bits ignored
      thresholds[4] = 32'd1;

      foreach (thresholds[p]) begin
         csr_write(ADDR_MIN_NORM_SQ, thresholds[p]);
         if (p == 3) csr_write(ADDR_UNMAPPED, 32'd0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 60 == 0) calm_tx = ($urandom_range(0, 2) == 0);
            if (p == 2 && i == PHASE_ITEMS / 2) begin
               req_if.valid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
            send_random();
         end
         req_if.valid <= 1'b0;
         drain();
      end

      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
